// ----- sv/alp_pkg.sv -----
// Package for the array linked list with free pool.
// Holds sizes, pointer types, operation codes and the structs shared by the modules.
// No dependencies.
package alp_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int PTR_W      = $clog2(DEPTH + 1);

	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [1:0]            op_t;

	localparam ptr_t NULL_PTR = PTR_W'(DEPTH);

	localparam op_t OP_PUSH_HEAD = 2'd0;
	localparam op_t OP_POP_HEAD  = 2'd1;
	localparam op_t OP_PUSH_TAIL = 2'd2;

	typedef struct packed {
		logic en;
		op_t  op;
	} alp_cmd_t;

	typedef struct packed {
		logic error;
		logic pop_ok;
		logic wr_en;
		idx_t wr_idx;
		idx_t rd_idx;
		logic list_empty;
		logic pool_full;
	} alp_res_t;

endpackage

// ----- sv/alp_req_if.sv -----
// Request channel: operation code and item value with valid/ready.
// Depends on alp_pkg.
interface alp_req_if;
	import alp_pkg::*;

	logic  valid;
	logic  ready;
	op_t   operation;
	data_t item_value;

	modport source (output valid, output operation, output item_value, input ready);
	modport sink (input valid, input operation, input item_value, output ready);
endinterface

// ----- sv/alp_rsp_if.sv -----
// Result channel: popped value and status flags with valid/ready.
// Depends on alp_pkg.
interface alp_rsp_if;
	import alp_pkg::*;

	logic  valid;
	logic  ready;
	data_t popped_value;
	logic  error;
	logic  list_empty;
	logic  pool_full;

	modport source (output valid, output popped_value, output error, output list_empty,
		output pool_full, input ready);
	modport sink (input valid, input popped_value, input error, input list_empty,
		input pool_full, output ready);
endinterface

// ----- sv/alp_links.sv -----
// Link store and list/free pointers of the node pool; one operation per enabled cycle.
// Reports the data store write/read indexes and the flags after the step.
// Depends on alp_pkg.
module alp_links (
	input  logic              clk,
	input  logic              arst_n,
	input  alp_pkg::alp_cmd_t cmd,
	output alp_pkg::alp_res_t res
);
	import alp_pkg::*;

	ptr_t link_q [DEPTH];
	ptr_t link_d [DEPTH];
	ptr_t head_q, tail_q, free_q;
	ptr_t head_d, tail_d, free_d;

	logic head_ok, tail_ok, free_ok;
	logic is_push, is_pop, push_ok, pop_ok;
	idx_t head_idx, tail_idx, free_idx;

	always_comb begin
		head_ok  = head_q < NULL_PTR;
		tail_ok  = tail_q < NULL_PTR;
		free_ok  = free_q < NULL_PTR;
		head_idx = head_q[IDX_W-1:0];
		tail_idx = tail_q[IDX_W-1:0];
		free_idx = free_q[IDX_W-1:0];
		is_push  = (cmd.op == OP_PUSH_HEAD) || (cmd.op == OP_PUSH_TAIL);
		is_pop   = cmd.op == OP_POP_HEAD;
		push_ok  = is_push && free_ok;
		pop_ok   = is_pop && head_ok;

		link_d = link_q;
		head_d = head_q;
		tail_d = tail_q;
		free_d = free_q;
		if (push_ok) begin
			free_d = link_q[free_idx];
			if (cmd.op == OP_PUSH_HEAD) begin
				link_d[free_idx] = head_q;
				head_d = free_q;
				if (!tail_ok) begin
					tail_d = free_q;
				end
			end else begin
				link_d[free_idx] = NULL_PTR;
				if (tail_ok) begin
					link_d[tail_idx] = free_q;
				end
				tail_d = free_q;
				if (!head_ok) begin
					head_d = free_q;
				end
			end
		end else if (pop_ok) begin
			head_d = link_q[head_idx];
			if (!(link_q[head_idx] < NULL_PTR)) begin
				tail_d = NULL_PTR;
			end
			link_d[head_idx] = free_q;
			free_d = head_q;
		end

		res.error      = (is_push && !free_ok) || (is_pop && !head_ok);
		res.pop_ok     = pop_ok;
		res.wr_en      = cmd.en && push_ok;
		res.wr_idx     = free_idx;
		res.rd_idx     = head_idx;
		res.list_empty = !(head_d < NULL_PTR);
		res.pool_full  = !(free_d < NULL_PTR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				link_q[i] <= PTR_W'(i + 1);
			end
			head_q <= NULL_PTR;
			tail_q <= NULL_PTR;
			free_q <= '0;
		end else if (cmd.en) begin
			link_q <= link_d;
			head_q <= head_d;
			tail_q <= tail_d;
			free_q <= free_d;
		end
	end
endmodule

// ----- sv/array_linked_list_with_free_pool_top.sv -----
// Top level of the array linked list with free pool: input register, node data store,
// result register. Depends on alp_pkg, alp_req_if, alp_rsp_if and alp_links.
//
// Usage:
//   req carries operation (push at head, pop from head, push at tail) and item_value;
//   a transfer happens when valid and ready are high at a rising edge of clk.
//   rsp carries popped_value, error, list_empty and pool_full, one result per request.
//   The request passes through the input register, then the result register that also
//   captures the registered node data read.
//   Throughput: one request per cycle while rsp is not stalled; each operation is finished
//   while it is in the input register, so back-to-back requests see each other's updates.
//   Stall: while rsp.valid is high and rsp.ready low, the result holds and the input
//   register holds; req.ready drops once the input register is also occupied.
//   Reset (arst_n low): list empty, all nodes free in index order, no result pending.
//   Node data is not cleared; it is only returned in popped_value after a push has written it.
module array_linked_list_with_free_pool_top (
	input logic clk,
	input logic arst_n,
	alp_req_if.sink   req,
	alp_rsp_if.source rsp
);
	import alp_pkg::*;

	logic  s1_valid_q;
	op_t   op_s1;
	data_t value_s1;

	logic  out_valid_q;
	logic  pop_ok_q;
	logic  error_q;
	logic  list_empty_q;
	logic  pool_full_q;
	data_t rd_data_q;

	data_t node_data [DEPTH];

	logic     advance;
	alp_cmd_t cmd;
	alp_res_t res;

	assign advance   = !out_valid_q || rsp.ready;
	assign req.ready = !s1_valid_q || advance;
	assign cmd.en    = advance && s1_valid_q;
	assign cmd.op    = op_s1;

	alp_links u_links (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				s1_valid_q <= req.valid;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready) begin
			op_s1    <= req.operation;
			value_s1 <= req.item_value;
		end
		if (advance) begin
			pop_ok_q     <= res.pop_ok;
			error_q      <= res.error;
			list_empty_q <= res.list_empty;
			pool_full_q  <= res.pool_full;
		end
	end

	always_ff @(posedge clk) begin
		if (res.wr_en) begin
			node_data[res.wr_idx] <= value_s1;
		end
		if (advance) begin
			rd_data_q <= node_data[res.rd_idx];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = pop_ok_q ? rd_data_q : '0;
	assign rsp.error        = error_q;
	assign rsp.list_empty   = list_empty_q;
	assign rsp.pool_full    = pool_full_q;
endmodule

// ----- bench/testbench.sv -----
// Testbench for array_linked_list_with_free_pool_top: directed and random push/pop traffic,
// with each result checked against a tracked copy of the node pool, in transfer order.
// Depends on alp_pkg, alp_req_if, alp_rsp_if and the top level of the block.
`timescale 1ns / 100ps

module testbench;
	import alp_pkg::*;

	localparam op_t OP_UNUSED    = 2'd3;
	localparam int  REPORT_LIMIT = 10;
	localparam int  RANDOM_ITEMS = 550;
	localparam int  LONG_HOLD    = 60;
	localparam int  SETTLE       = 8;

	typedef struct {
		data_t popped_value;
		logic  error;
		logic  list_empty;
		logic  pool_full;
	} reply_t;

	class linked_list_tracker;
		data_t  node_data[DEPTH];
		ptr_t   node_link[DEPTH];
		ptr_t   list_head;
		ptr_t   list_tail;
		ptr_t   free_head;
		reply_t replies[$];
		int     mismatches;

		function new();
			for (int i = 0; i < DEPTH; i++) begin
				node_data[i] = '0;
				node_link[i] = ptr_t'(i + 1);
			end
			list_head  = NULL_PTR;
			list_tail  = NULL_PTR;
			free_head  = '0;
			mismatches = 0;
		endfunction

		function bit holds_node(ptr_t p);
			return p < DEPTH;
		endfunction

		function void note_request(op_t op, data_t val);
			reply_t r;
			ptr_t   p;
			r.popped_value = '0;
			r.error        = 1'b0;
			if (op == OP_PUSH_HEAD || op == OP_PUSH_TAIL) begin
				p = free_head;
				if (!holds_node(p)) begin
					r.error = 1'b1;
				end else begin
					free_head    = node_link[p];
					node_data[p] = val;
					if (op == OP_PUSH_HEAD) begin
						node_link[p] = list_head;
						list_head    = p;
						if (!holds_node(list_tail))
							list_tail = p;
					end else begin
						node_link[p] = NULL_PTR;
						if (holds_node(list_tail))
							node_link[list_tail] = p;
						list_tail = p;
						if (!holds_node(list_head))
							list_head = p;
					end
				end
			end else if (op == OP_POP_HEAD) begin
				p = list_head;
				if (!holds_node(p)) begin
					r.error = 1'b1;
				end else begin
					r.popped_value = node_data[p];
					list_head      = node_link[p];
					if (!holds_node(list_head))
						list_tail = NULL_PTR;
					node_link[p] = free_head;
					free_head    = p;
				end
			end
			r.list_empty = !holds_node(list_head);
			r.pool_full  = !holds_node(free_head);
			replies.push_back(r);
		endfunction

		function void check_reply(data_t pv, logic err, logic le, logic pf);
			reply_t want;
			if (replies.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result popped=%h error=%b empty=%b full=%b",
						$realtime, pv, err, le, pf);
				return;
			end
			want = replies.pop_front();
			if (pv !== want.popped_value || err !== want.error || le !== want.list_empty ||
					pf !== want.pool_full) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: expected popped=%h error=%b empty=%b full=%b, got %h %b %b %b",
						$realtime, want.popped_value, want.error, want.list_empty,
						want.pool_full, pv, err, le, pf);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	bit   hold_request;

	alp_req_if req();
	alp_rsp_if rsp();

	linked_list_tracker tracker = new();

	array_linked_list_with_free_pool_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_item(op_t op, data_t val);
		req.valid      <= 1'b1;
		req.operation  <= op;
		req.item_value <= val;
		do @(posedge clk); while (!req.ready);
		tracker.note_request(op, val);
	endtask

	task automatic sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 75)
			return;
		req.valid <= 1'b0;
		if (r < 95)
			repeat ($urandom_range(1, 3)) @(posedge clk);
		else
			repeat ($urandom_range(8, 25)) @(posedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (tracker.replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return data_t'($urandom_range(0, 15));
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic op_t pick_operation(bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return OP_UNUSED;
		if (r < (filling ? 80 : 20))
			return $urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
		return OP_POP_HEAD;
	endfunction

	// result side: random backpressure, plus one long hold on request
	initial begin
		int r;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				tracker.check_reply(rsp.popped_value, rsp.error, rsp.list_empty, rsp.pool_full);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else if (calm) begin
				rsp.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					rsp.ready <= 1'b1;
				end else begin
					rsp.ready <= 1'b0;
					if (r < 96)
						repeat ($urandom_range(1, 3) - 1) @(posedge clk);
					else
						repeat ($urandom_range(8, 25) - 1) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int  sent;
		int  phase_len;
		bit  filling;
		arst_n          = 1'b0;
		calm            = 1'b0;
		hold_request    = 1'b0;
		req.valid      <= 1'b0;
		req.operation  <= OP_PUSH_HEAD;
		req.item_value <= '0;
		rsp.ready      <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_POP_HEAD, 32'h1234_5678);
		send_item(OP_UNUSED, '1);
		send_item(OP_PUSH_HEAD, '0);
		sender_gap();
		send_item(OP_PUSH_TAIL, '1);
		send_item(OP_POP_HEAD, '0);
		send_item(OP_POP_HEAD, '1);
		for (int i = 0; i < DEPTH; i++) begin
			send_item((i % 2) ? OP_PUSH_TAIL : OP_PUSH_HEAD, 32'hA5A5_0000 | i);
			sender_gap();
		end
		send_item(OP_PUSH_HEAD, 32'hDEAD_BEEF);
		send_item(OP_PUSH_TAIL, 32'h5A5A_5A5A);
		wait_drained();

		sent    = 0;
		filling = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(10, 50);
			calm      = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				if (sent == 150) begin
					calm         = 1'b1;
					hold_request = 1'b1;
				end
				send_item(pick_operation(filling), pick_value());
				sent++;
				if (sent == 300)
					wait_drained();
				else
					sender_gap();
			end
			filling = ~filling;
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
